FILE: src/tmean_pkg.sv
// Shared types and fixed widths for the accelerometer trimmed-mean filter.
// No dependencies; used by tmean_acc, tmean_div and accel_block_trimmed_mean.
package tmean_pkg;

    localparam int NUM_AXES  = 3;
    localparam int BYTE_W    = 8;
    localparam int SAMPLE_W  = 12;
    localparam int SUM_W     = 18;
    localparam int TRIM_W    = 20;
    localparam int MAG_W     = 17;
    localparam int FRAC_W    = 8;
    localparam int DIV_IN_W  = MAG_W + FRAC_W;
    localparam int QUOT_W    = 20;
    localparam int MEAN_W    = 20;
    localparam int S_DATA_W  = 2 * NUM_AXES * BYTE_W;
    localparam int M_DATA_W  = ((NUM_AXES * MEAN_W + 7) / 8) * 8;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 12'sh7FF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 12'sh800;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [MEAN_W-1:0]   mean_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        sample_t                 mn;
        sample_t                 mx;
    } axis_acc_t;

    typedef axis_acc_t [NUM_AXES-1:0] block_t;
    typedef mean_t     [NUM_AXES-1:0] means_t;

endpackage

FILE: src/tmean_acc.sv
// Block accumulator: decodes the three axis samples of each item and keeps the
// running sum, minimum and maximum; hands a completed block on. Uses tmean_pkg.
module tmean_acc #(
    parameter int BLOCK_SIZE = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tmean_pkg::S_DATA_W-1:0]  in_data,
    output logic                            blk_valid,
    input  logic                            blk_ready,
    output tmean_pkg::block_t               blk_data
);

    localparam int CNT_W = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(BLOCK_SIZE - 1);

    logic [CNT_W-1:0]   count_reg, count_next;
    tmean_pkg::block_t  acc_reg, acc_next;
    tmean_pkg::block_t  blk_reg, blk_next;
    logic               blk_valid_reg, blk_valid_next;
    tmean_pkg::block_t  upd;
    tmean_pkg::block_t  cleared;
    logic               last;
    logic               accept;

    assign last      = (count_reg == LAST_CNT);
    assign in_ready  = !last || !blk_valid_reg || blk_ready;
    assign accept    = in_valid && in_ready;
    assign blk_valid = blk_valid_reg;
    assign blk_data  = blk_reg;

    always_comb begin
        for (int a = 0; a < tmean_pkg::NUM_AXES; a++) begin
            tmean_pkg::sample_t v;
            v = tmean_pkg::sample_t'({in_data[(2*a)*tmean_pkg::BYTE_W +: tmean_pkg::BYTE_W],
                                      in_data[(2*a+1)*tmean_pkg::BYTE_W + 4 +: 4]});
            upd[a].sum = acc_reg[a].sum + tmean_pkg::SUM_W'(v);
            upd[a].mn  = (v < acc_reg[a].mn) ? v : acc_reg[a].mn;
            upd[a].mx  = (v > acc_reg[a].mx) ? v : acc_reg[a].mx;
            cleared[a].sum = '0;
            cleared[a].mn  = tmean_pkg::SAMPLE_MAX;
            cleared[a].mx  = tmean_pkg::SAMPLE_MIN;
        end
    end

    always_comb begin
        count_next     = count_reg;
        acc_next       = acc_reg;
        blk_next       = blk_reg;
        blk_valid_next = blk_valid_reg && !blk_ready;
        if (accept) begin
            if (last) begin
                count_next     = '0;
                acc_next       = cleared;
                blk_next       = upd;
                blk_valid_next = 1'b1;
            end else begin
                count_next = count_reg + 1'b1;
                acc_next   = upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            acc_reg       <= cleared;
            blk_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            acc_reg       <= acc_next;
            blk_valid_reg <= blk_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
    end

endmodule

FILE: src/tmean_div.sv
// Trim and divide pipeline: drops min and max when BLOCK_SIZE is at least 3, scales by 256 and divides by
// the build-time block divisor with an exact reciprocal multiply. Uses tmean_pkg.
module tmean_div #(
    parameter int BLOCK_SIZE = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  tmean_pkg::block_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tmean_pkg::means_t   out_data
);

    localparam int  N        = tmean_pkg::NUM_AXES;
    localparam bit  TRIM     = (BLOCK_SIZE >= 3);
    localparam int  DIVISOR  = (BLOCK_SIZE <= 2) ? BLOCK_SIZE : BLOCK_SIZE - 2;
    localparam int  SHIFT    = tmean_pkg::DIV_IN_W + $clog2(DIVISOR);
    localparam int  RECIP_W  = SHIFT + 1;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam int  PROD_W   = tmean_pkg::DIV_IN_W + RECIP_W;

    logic                                v1_reg, v2_reg, v3_reg;
    logic                                rdy1, rdy2, rdy3;
    logic [N-1:0]                        neg1_reg, neg2_reg;
    logic [N-1:0][tmean_pkg::MAG_W-1:0]  mag1_reg, mag1_next;
    logic [N-1:0]                        neg1_next;
    logic [N-1:0][tmean_pkg::QUOT_W-1:0] quot2_reg, quot2_next;
    tmean_pkg::means_t                   mean3_reg, mean3_next;

    assign rdy3      = !v3_reg || out_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign in_ready  = rdy1;
    assign out_valid = v3_reg;
    assign out_data  = mean3_reg;

    always_comb begin
        for (int a = 0; a < N; a++) begin
            logic signed [tmean_pkg::TRIM_W-1:0] t;
            logic        [tmean_pkg::TRIM_W-1:0] m;
            logic        [PROD_W-1:0]            prod;
            logic        [tmean_pkg::QUOT_W-1:0] q;
            t = TRIM ? (tmean_pkg::TRIM_W'(in_data[a].sum) - tmean_pkg::TRIM_W'(in_data[a].mn)
                        - tmean_pkg::TRIM_W'(in_data[a].mx))
                     : tmean_pkg::TRIM_W'(in_data[a].sum);
            m = t[tmean_pkg::TRIM_W-1] ? -t : t;
            neg1_next[a] = t[tmean_pkg::TRIM_W-1];
            mag1_next[a] = m[tmean_pkg::MAG_W-1:0];

            prod = PROD_W'({mag1_reg[a], {tmean_pkg::FRAC_W{1'b0}}}) * PROD_W'(RECIP);
            quot2_next[a] = prod[SHIFT +: tmean_pkg::QUOT_W];

            q = quot2_reg[a];
            mean3_next[a] = neg2_reg[a] ? -q : q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            mag1_reg <= mag1_next;
            neg1_reg <= neg1_next;
        end
        if (rdy2) begin
            quot2_reg <= quot2_next;
            neg2_reg  <= neg1_reg;
        end
        if (rdy3) begin
            mean3_reg <= mean3_next;
        end
    end

endmodule

FILE: src/accel_block_trimmed_mean.sv
// Top level of the accelerometer trimmed-mean block filter.
// Instantiates tmean_acc and tmean_div; uses tmean_pkg.
//
//   channel   dir  fields (tdata, lowest bit first)
//   s_axis    in   x_high, x_low, y_high, y_low, z_high, z_low (8 bits each)
//   m_axis    out  x_mean, y_mean, z_mean (20 bits signed each, Q.8)
//
// One item per cycle is taken while s_tready is high; every BLOCK_SIZE-th item completes a block.
// The block result is registered in the accumulator's block register and then passes
// through a three-stage trim, multiply and sign pipeline before it is offered.
// aresetn clears the block count, sums, minima, maxima and all stage valids.
// A stalled result only holds the input when the pipeline is full and the
// next item would complete another block.
module accel_block_trimmed_mean #(
    parameter int BLOCK_SIZE = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tmean_pkg::S_DATA_W-1:0] s_tdata,  // x_high, x_low, y_high, y_low, z_high, z_low
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tmean_pkg::M_DATA_W-1:0] m_tdata   // x_mean, y_mean, z_mean, zero pad
);

    logic               blk_valid;
    logic               blk_ready;
    tmean_pkg::block_t  blk_data;
    tmean_pkg::means_t  means;

    tmean_acc #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk_data  (blk_data)
    );

    tmean_div #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (blk_valid),
        .in_ready  (blk_ready),
        .in_data   (blk_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (means)
    );

    assign m_tdata = tmean_pkg::M_DATA_W'(means);

endmodule

FILE: tb/tmean_check.sv
// Checker for the accelerometer trimmed-mean filter: watches both stream channels,
// predicts each block result from the accepted samples and compares it per axis.
// Depends on tmean_pkg for widths and the packed means type.
module tmean_check #(
    parameter int BLOCK_SIZE = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [tmean_pkg::S_DATA_W-1:0] s_tdata,  // x_high, x_low, y_high, y_low, z_high, z_low
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [tmean_pkg::M_DATA_W-1:0] m_tdata,  // x_mean, y_mean, z_mean, zero pad
    output int                             errors,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tmean_pkg::*;

    means_t  block_means[$];
    int      acc_sum[NUM_AXES];
    sample_t acc_min[NUM_AXES];
    sample_t acc_max[NUM_AXES];
    int      acc_count;
    int      mismatches;
    string   axis_name[NUM_AXES] = '{"x", "y", "z"};

    function automatic sample_t axis_sample(logic [BYTE_W-1:0] hi, logic [BYTE_W-1:0] lo);
        logic [2*BYTE_W-1:0] word;
        word = {hi, lo};
        return sample_t'(word[2*BYTE_W-1:4]);
    endfunction

    function automatic mean_t trim_mean(int sum, int mn, int mx);
        int q;
        if (BLOCK_SIZE <= 1) begin
            q = sum * (1 << FRAC_W);
        end else if (BLOCK_SIZE == 2) begin
            q = (sum * (1 << FRAC_W)) / 2;
        end else begin
            q = ((sum - mn - mx) * (1 << FRAC_W)) / (BLOCK_SIZE - 2);
        end
        return mean_t'(q[MEAN_W-1:0]);
    endfunction

    task automatic clear_block();
        acc_count = 0;
        for (int a = 0; a < NUM_AXES; a++) begin
            acc_sum[a] = 0;
            acc_min[a] = SAMPLE_MAX;
            acc_max[a] = SAMPLE_MIN;
        end
    endtask

    always @(posedge aclk) begin : monitor
        means_t  got;
        means_t  want;
        means_t  next_means;
        sample_t v;
        if (!aresetn) begin
            clear_block();
            block_means.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[NUM_AXES*MEAN_W-1:0];
                if (block_means.size() == 0) begin
                    if (mismatches < 10)
                        $display("%t: unexpected result, tdata %h", $realtime, m_tdata);
                    mismatches++;
                end else begin
                    want = block_means.pop_front();
                    for (int a = 0; a < NUM_AXES; a++) begin
                        if (got[a] !== want[a]) begin
                            if (mismatches < 10)
                                $display("%t: %s_mean mismatch, expected %0d, got %0d",
                                         $realtime, axis_name[a], want[a], got[a]);
                            mismatches++;
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    v = axis_sample(s_tdata[a*2*BYTE_W +: BYTE_W],
                                    s_tdata[a*2*BYTE_W+BYTE_W +: BYTE_W]);
                    acc_sum[a] += v;
                    if (v < acc_min[a])
                        acc_min[a] = v;
                    if (v > acc_max[a])
                        acc_max[a] = v;
                end
                acc_count++;
                if (acc_count >= BLOCK_SIZE) begin
                    for (int a = 0; a < NUM_AXES; a++)
                        next_means[a] = trim_mean(acc_sum[a], acc_min[a], acc_max[a]);
                    block_means.push_back(next_means);
                    clear_block();
                end
            end
        end
        pending <= block_means.size();
        errors  <= mismatches;
    end

endmodule

FILE: tb/accel_block_trimmed_mean_tb.sv
// Top of the trimmed-mean filter testbench: clock, reset, directed and random sample
// streams under varying idle and stall patterns, watchdog and verdict.
// Depends on tmean_pkg, accel_block_trimmed_mean and tmean_check.
module accel_block_trimmed_mean_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmean_pkg::*;

    localparam int BLOCK_SIZE      = 8;
    localparam int IDLE_LIMIT      = 2000;
    localparam int ITEMS_PER_PHASE = 400;
    localparam int DRAIN_CYCLES    = 16;
    localparam int NUM_PHASES      = 4;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tready = 1'b0;
    logic                s_tready;
    logic                m_tvalid;
    logic [M_DATA_W-1:0] m_tdata;

    int fails;
    int pending;
    int quiet_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int send_pct[NUM_PHASES] = '{0, 48, 0, 14};
    int recv_pct[NUM_PHASES] = '{0, 0, 48, 14};

    always #4 aclk = ~aclk;

    accel_block_trimmed_mean #(
        .BLOCK_SIZE(BLOCK_SIZE)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    tmean_check #(
        .BLOCK_SIZE(BLOCK_SIZE)
    ) check (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .errors  (fails),
        .pending (pending)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [S_DATA_W-1:0] pack_item(logic [11:0] x, logic [11:0] y,
                                                      logic [11:0] z, logic [3:0] nib);
        return {z[3:0], nib, z[11:4], y[3:0], nib, y[11:4], x[3:0], nib, x[11:4]};
    endfunction

    function automatic logic [11:0] random_sample();
        logic [11:0] v;
        v = 12'($urandom);
        case ($urandom_range(9))
            0: v = SAMPLE_MAX;
            1: v = SAMPLE_MIN;
            2: v = 12'h000;
            3: v = 12'hFFF;
            4: v = 12'($urandom_range(7)) - 12'd4;
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_item(logic [S_DATA_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes and ties
        send_item(pack_item(12'h7FF, 12'h800, 12'h7FF, 4'h0));
        send_item(pack_item(12'h7FF, 12'h800, 12'h7FF, 4'hF));
        send_item(pack_item(12'h800, 12'h800, 12'h7FF, 4'h0));
        send_item(pack_item(12'h800, 12'h800, 12'h7FF, 4'hA));
        send_item(pack_item(12'h000, 12'h800, 12'h7FF, 4'h5));
        send_item(pack_item(12'hFFF, 12'h800, 12'h7FF, 4'hF));
        send_item(pack_item(12'h001, 12'h800, 12'h7FF, 4'h0));
        send_item(pack_item(12'h7FF, 12'h800, 12'h7FF, 4'h3));
        // all-zero and all-one bytes, then mixed bit patterns
        send_item(pack_item(12'h000, 12'hFFF, 12'h000, 4'h0));
        send_item(pack_item(12'hFFF, 12'h000, 12'hFFF, 4'hF));
        send_item(pack_item(12'h000, 12'hFFF, 12'h000, 4'h0));
        send_item(pack_item(12'hFFF, 12'h000, 12'hFFF, 4'hF));
        send_item(pack_item(12'h000, 12'h000, 12'h000, 4'h0));
        send_item(pack_item(12'hFFF, 12'hFFF, 12'hFFF, 4'hF));
        send_item(pack_item(12'h555, 12'hAAA, 12'h123, 4'hC));
        send_item(pack_item(12'hAAA, 12'h555, 12'hEDC, 4'h3));
        // truncation toward zero on both signs
        send_item(pack_item(12'hFFF, 12'h001, 12'h800, 4'h9));
        send_item(pack_item(12'hFFF, 12'h001, 12'h7FF, 4'h6));
        send_item(pack_item(12'hFFE, 12'h002, 12'h800, 4'h0));
        send_item(pack_item(12'hFFF, 12'h001, 12'h7FF, 4'hF));
        send_item(pack_item(12'hFFF, 12'h001, 12'h800, 4'h1));
        send_item(pack_item(12'hFFF, 12'h001, 12'h7FF, 4'hE));
        send_item(pack_item(12'hFFE, 12'h002, 12'h800, 4'h7));
        send_item(pack_item(12'hFFF, 12'h001, 12'h7FF, 4'h8));
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct   = send_pct[p];
            recv_stall_pct <= recv_pct[p];
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (i == ITEMS_PER_PHASE / 2)
                    settle();
                send_item(pack_item(random_sample(), random_sample(), random_sample(),
                                    4'($urandom)));
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fails == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
